>>> rtl/brf_pkg.sv
`default_nettype none

package brf_pkg;

  localparam int BYTE_W  = 8;
  localparam int REQ_W   = 3;
  localparam int COUNT_W = 16;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 48;
  localparam int CFG_ADDR_W = 3;

  localparam logic [REQ_W-1:0] REQ_WRITE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FIND  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FLUSH = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Word index of the mode register on the configuration port.
  localparam logic REG_MODE = 1'b0;

endpackage

`default_nettype wire

>>> rtl/brf_ram.sv
`default_nettype none

module brf_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [ADDR_W-1:0]          wr_addr,
  input  wire logic [brf_pkg::BYTE_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  output      logic [brf_pkg::BYTE_W-1:0] rd_data
);

  logic [brf_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/byte_ring_fifo_pushout_unit.sv
// Byte ring FIFO of DEPTH slots holding at most DEPTH-1 bytes, with an
// optional push-out of the oldest byte when a write meets a full FIFO.
// Requests arrive on the s_ stream (write, read, peek, find, flush) and each
// produces exactly one result word on the m_ stream, carrying the byte read,
// an ok flag, the match offset of a find, the fill level and the burst count.
// The mode register (drop or push-out) sits at word 0 of the APB port.
// One request is handled at a time; s_tready is high only while the
// sequencer is idle. Write, flush and unknown requests go from idle to
// S_DONE, read and peek of a non-empty FIFO pass through S_MEM first
// because of the registered read of the byte store. Find walks the store
// through the same single read port, issuing each read in S_FIND and
// comparing it in S_CMP, until the first match or until every stored
// byte has been examined.
// Results sit in an output register; a new request is accepted while a
// result waits, but that request's own result is held in the sequencer
// until the receiver has taken the earlier word.
// Reset empties the FIFO, clears the burst count and selects drop mode;
// the byte store itself is not cleared, as only written bytes are read.
`default_nettype none

module byte_ring_fifo_pushout_unit #(
  parameter int DEPTH = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // s_tdata: req_type[2:0], data_in[10:3], peek_offset[18:11], ref_byte[26:19]
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  input  wire logic [brf_pkg::S_DATA_W-1:0]      s_tdata,
  input  wire logic                              s_tlast,
  // m_tdata: data_out[7:0], ok[8], match_offset[16:9], level[24:17],
  // burst_count[40:25]
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  output      logic [brf_pkg::M_DATA_W-1:0]      m_tdata,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [brf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                       pwdata,
  output      logic [31:0]                       prdata,
  output      logic                              pready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CMP_W = (PTR_W > brf_pkg::BYTE_W) ? PTR_W : brf_pkg::BYTE_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEM,
    S_FIND,
    S_CMP,
    S_DONE
  } state_t;

  state_t state;

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] fill;
  logic [brf_pkg::COUNT_W-1:0] burst;
  logic overwrite_mode;

  logic [PTR_W-1:0] scan_ptr;
  logic [PTR_W-1:0] scan_idx;
  logic [brf_pkg::BYTE_W-1:0] r_ref;
  logic [brf_pkg::BYTE_W-1:0] r_data;
  logic r_ok;
  logic [brf_pkg::BYTE_W-1:0] r_moff;
  logic [brf_pkg::BYTE_W-1:0] r_level;
  logic [brf_pkg::COUNT_W-1:0] r_burst;

  logic [brf_pkg::REQ_W-1:0]  req;
  logic [brf_pkg::BYTE_W-1:0] din;
  logic [brf_pkg::BYTE_W-1:0] poff;
  logic [brf_pkg::BYTE_W-1:0] refb;
  logic accept;
  logic cfg_wr;

  logic full;
  logic empty;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;
  logic [PTR_W-1:0] scan_inc;
  logic write_ok;
  logic move_ok;
  logic [brf_pkg::COUNT_W-1:0] burst_rep;
  logic [PTR_W-1:0] fill_next;
  logic [CMP_W-1:0] fill_next_x;
  logic [CMP_W-1:0] fill_x;
  logic [CMP_W-1:0] poff_x;
  logic [CMP_W-1:0] idx_x;
  logic [PTR_W-1:0] peek_off;
  logic [PTR_W:0]   peek_sum;
  logic [PTR_W:0]   peek_wrap;
  logic [PTR_W-1:0] peek_addr;

  logic wr_en;
  logic [PTR_W-1:0] rd_addr;
  logic [brf_pkg::BYTE_W-1:0] rd_data;

  assign req  = s_tdata[2:0];
  assign din  = s_tdata[10:3];
  assign poff = s_tdata[18:11];
  assign refb = s_tdata[26:19];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == brf_pkg::REG_MODE) begin
      prdata[0] = overwrite_mode;
    end
  end

  assign full     = (fill == LAST_SLOT);
  assign empty    = (fill == '0);
  assign head_inc = (head == LAST_SLOT) ? '0 : head + PTR_W'(1);
  assign tail_inc = (tail == LAST_SLOT) ? '0 : tail + PTR_W'(1);
  assign scan_inc = (scan_ptr == LAST_SLOT) ? '0 : scan_ptr + PTR_W'(1);

  assign write_ok = !full || overwrite_mode;
  assign move_ok  = ((req == brf_pkg::REQ_WRITE) && write_ok) ||
                    ((req == brf_pkg::REQ_READ) && !empty);
  assign burst_rep = (move_ok && (burst != brf_pkg::COUNT_MAX)) ?
                     burst + brf_pkg::COUNT_W'(1) : burst;

  always_comb begin
    case (req)
      brf_pkg::REQ_WRITE: fill_next = (!full) ? fill + PTR_W'(1) : fill;
      brf_pkg::REQ_READ:  fill_next = (!empty) ? fill - PTR_W'(1) : fill;
      brf_pkg::REQ_FLUSH: fill_next = '0;
      default:            fill_next = fill;
    endcase
  end

  assign fill_next_x = CMP_W'(fill_next);
  assign fill_x      = CMP_W'(fill);
  assign poff_x      = CMP_W'(poff);
  assign idx_x       = CMP_W'(scan_idx);

  // Peek offsets past the last stored byte are pulled back onto it.
  assign peek_off  = (poff_x >= fill_x) ? fill - PTR_W'(1) : poff_x[PTR_W-1:0];
  assign peek_sum  = {1'b0, head} + {1'b0, peek_off};
  assign peek_wrap = peek_sum - DEPTH_X;
  assign peek_addr = (peek_sum >= DEPTH_X) ? peek_wrap[PTR_W-1:0] :
                                             peek_sum[PTR_W-1:0];

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = (req == brf_pkg::REQ_PEEK) ? peek_addr : head;
      S_FIND:  rd_addr = scan_ptr;
      default: rd_addr = head;
    endcase
  end

  assign wr_en = accept && (req == brf_pkg::REQ_WRITE) && write_ok;

  brf_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (din),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      head           <= '0;
      tail           <= '0;
      fill           <= '0;
      burst          <= '0;
      overwrite_mode <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == brf_pkg::REG_MODE)) begin
        overwrite_mode <= pwdata[0];
      end
      // A word leaving in the same cycle as the next is loaded is
      // handled in S_DONE.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            r_data   <= '0;
            r_moff   <= '0;
            r_ref    <= refb;
            r_level  <= fill_next_x[brf_pkg::BYTE_W-1:0];
            r_burst  <= burst_rep;
            scan_idx <= '0;
            scan_ptr <= head;
            fill     <= fill_next;
            if ((req == brf_pkg::REQ_WRITE) || (req == brf_pkg::REQ_READ)) begin
              burst <= s_tlast ? '0 : burst_rep;
            end
            case (req)
              brf_pkg::REQ_WRITE: begin
                r_ok  <= write_ok;
                state <= S_DONE;
                if (write_ok) begin
                  tail <= tail_inc;
                  // In push-out mode a full FIFO loses its oldest byte.
                  if (full) begin
                    head <= head_inc;
                  end
                end
              end
              brf_pkg::REQ_READ: begin
                r_ok <= !empty;
                if (!empty) begin
                  head  <= head_inc;
                  state <= S_MEM;
                end else begin
                  state <= S_DONE;
                end
              end
              brf_pkg::REQ_PEEK: begin
                r_ok  <= !empty;
                state <= empty ? S_DONE : S_MEM;
              end
              brf_pkg::REQ_FIND: begin
                r_ok  <= 1'b0;
                state <= S_FIND;
              end
              brf_pkg::REQ_FLUSH: begin
                head  <= '0;
                tail  <= '0;
                r_ok  <= 1'b1;
                state <= S_DONE;
              end
              default: begin
                r_ok  <= 1'b0;
                state <= S_DONE;
              end
            endcase
          end
        end

        S_MEM: begin
          r_data <= rd_data;
          state  <= S_DONE;
        end

        // The read of scan_ptr is issued here and compared in the next cycle.
        S_FIND: begin
          if (scan_idx == fill) begin
            state <= S_DONE;
          end else begin
            state <= S_CMP;
          end
        end

        S_CMP: begin
          if (rd_data == r_ref) begin
            r_ok   <= 1'b1;
            r_moff <= idx_x[brf_pkg::BYTE_W-1:0];
            state  <= S_DONE;
          end else begin
            scan_idx <= scan_idx + PTR_W'(1);
            scan_ptr <= scan_inc;
            state    <= S_FIND;
          end
        end

        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, r_burst, r_level, r_moff, r_ok, r_data};
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sim/byte_ring_fifo_pushout_unit_test.sv
`timescale 1ns / 100ps

module byte_ring_fifo_pushout_unit_test;

  localparam int DEPTH = 256;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam logic [brf_pkg::CFG_ADDR_W-1:0] MODE_ADDR =
    brf_pkg::CFG_ADDR_W'(4 * brf_pkg::REG_MODE);
  localparam logic MODE_DROP = 1'b0;
  localparam logic MODE_PUSHOUT = 1'b1;

  // Request codes the block must treat as unknown.
  localparam logic [brf_pkg::REQ_W-1:0] REQ_RSVD5 = 3'd5;
  localparam logic [brf_pkg::REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [brf_pkg::REQ_W-1:0] REQ_RSVD7 = 3'd7;

  typedef struct packed {
    logic [brf_pkg::REQ_W-1:0]  kind;
    logic [brf_pkg::BYTE_W-1:0] wbyte;
    logic [brf_pkg::BYTE_W-1:0] offset;
    logic [brf_pkg::BYTE_W-1:0] needle;
    logic                       last;
  } fifo_req_t;

  typedef struct packed {
    logic [brf_pkg::BYTE_W-1:0]  rbyte;
    logic                        ok;
    logic [brf_pkg::BYTE_W-1:0]  hit_offset;
    logic [brf_pkg::BYTE_W-1:0]  fill;
    logic [brf_pkg::COUNT_W-1:0] burst;
  } fifo_result_t;

  typedef struct packed {
    fifo_req_t    req;
    logic         chk;
    fifo_result_t want;
  } directed_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           s_tvalid;
  logic                           s_tready;
  logic [brf_pkg::S_DATA_W-1:0]   s_tdata;
  logic                           s_tlast;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [brf_pkg::M_DATA_W-1:0]   m_tdata;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [brf_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  byte_ring_fifo_pushout_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the ring, its pointers, the burst count and the mode.
  logic [brf_pkg::BYTE_W-1:0]  ring_bytes [DEPTH];
  int unsigned                 rd_ptr = 0;
  int unsigned                 wr_ptr = 0;
  logic [brf_pkg::COUNT_W-1:0] burst_run = '0;
  logic                        pushout = MODE_DROP;

  fifo_result_t pending_results [$];
  directed_step_t dir_steps [$];
  logic failed = 1'b0;
  logic quiet = 1'b0;
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned held();
    return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
  endfunction

  function automatic fifo_result_t apply_request(input fifo_req_t r);
    fifo_result_t res;
    int unsigned fill;
    int unsigned off;
    int unsigned i;
    logic moves;
    res = '0;
    fill = held();
    moves = (r.kind == brf_pkg::REQ_WRITE) || (r.kind == brf_pkg::REQ_READ);
    case (r.kind)
      brf_pkg::REQ_WRITE: begin
        if (fill < DEPTH - 1 || pushout) begin
          // A full ring in push-out mode gives up its oldest byte first.
          if (fill >= DEPTH - 1) rd_ptr = (rd_ptr + 1) % DEPTH;
          ring_bytes[wr_ptr] = r.wbyte;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          res.ok = 1'b1;
        end
      end
      brf_pkg::REQ_READ: begin
        if (fill != 0) begin
          res.rbyte = ring_bytes[rd_ptr];
          rd_ptr = (rd_ptr + 1) % DEPTH;
          res.ok = 1'b1;
        end
      end
      brf_pkg::REQ_PEEK: begin
        if (fill != 0) begin
          off = (r.offset >= fill) ? fill - 1 : r.offset;
          res.rbyte = ring_bytes[(rd_ptr + off) % DEPTH];
          res.ok = 1'b1;
        end
      end
      brf_pkg::REQ_FIND: begin
        for (i = 0; i < fill && !res.ok; i++) begin
          if (ring_bytes[(rd_ptr + i) % DEPTH] == r.needle) begin
            res.ok = 1'b1;
            res.hit_offset = i[brf_pkg::BYTE_W-1:0];
          end
        end
      end
      brf_pkg::REQ_FLUSH: begin
        rd_ptr = 0;
        wr_ptr = 0;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    if (moves && res.ok && burst_run != brf_pkg::COUNT_MAX) burst_run = burst_run + 1'b1;
    res.burst = burst_run;
    if (moves && r.last) burst_run = '0;
    res.fill = brf_pkg::BYTE_W'(held());
    return res;
  endfunction

  function automatic fifo_req_t rq(input logic [brf_pkg::REQ_W-1:0] kind,
                                   input logic [brf_pkg::BYTE_W-1:0] wbyte, offset, needle,
                                   input logic last);
    return {kind, wbyte, offset, needle, last};
  endfunction

  function automatic fifo_result_t rs(input logic [brf_pkg::BYTE_W-1:0] rbyte,
                                      input logic ok,
                                      input logic [brf_pkg::BYTE_W-1:0] hit_offset, fill,
                                      input logic [brf_pkg::COUNT_W-1:0] burst);
    return {rbyte, ok, hit_offset, fill, burst};
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = MODE_ADDR;
    pwdata = {31'd0, mode};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    pushout = mode;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_request(input fifo_req_t r, input logic chk, input fifo_result_t want);
    int gap;
    fifo_result_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {5'd0, r.needle, r.offset, r.wbyte, r.kind};
    s_tlast = r.last;
    do @(posedge clk); while (!s_tready);
    predicted = apply_request(r);
    pending_results.push_back(chk ? want : predicted);
  endtask

  task automatic run_phase(input logic mode, input int count,
                           input int w_wr, input int w_rd, input int w_pk,
                           input int w_fd, input int w_fl);
    fifo_req_t r;
    int roll;
    int unsigned fill;
    wait_drained();
    write_mode(mode);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      fill = held();
      roll = $urandom_range(0, 99);
      if (roll < w_wr) r.kind = brf_pkg::REQ_WRITE;
      else if (roll < w_wr + w_rd) r.kind = brf_pkg::REQ_READ;
      else if (roll < w_wr + w_rd + w_pk) r.kind = brf_pkg::REQ_PEEK;
      else if (roll < w_wr + w_rd + w_pk + w_fd) r.kind = brf_pkg::REQ_FIND;
      else if (roll < w_wr + w_rd + w_pk + w_fd + w_fl) r.kind = brf_pkg::REQ_FLUSH;
      else r.kind = brf_pkg::REQ_W'($urandom_range(REQ_RSVD5, REQ_RSVD7));
      r.wbyte = brf_pkg::BYTE_W'($urandom_range(0, 255));
      if (fill != 0 && $urandom_range(0, 1) == 1)
        r.offset = brf_pkg::BYTE_W'($urandom_range(0, fill - 1));
      else
        r.offset = brf_pkg::BYTE_W'($urandom_range(0, 255));
      // With a non-empty ring, half of the searches look for a byte known to be held.
      if (fill != 0 && $urandom_range(0, 1) == 1)
        r.needle = ring_bytes[(rd_ptr + $urandom_range(0, fill - 1)) % DEPTH];
      else
        r.needle = brf_pkg::BYTE_W'($urandom_range(0, 255));
      if (r.kind == brf_pkg::REQ_WRITE || r.kind == brf_pkg::REQ_READ)
        r.last = ($urandom_range(0, 9) == 0);
      else
        r.last = 1'($urandom_range(0, 1));
      send_request(r, 1'b0, '0);
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  task automatic check_field(input string name, input logic [brf_pkg::COUNT_W-1:0] want,
                             input logic [brf_pkg::COUNT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Result side: random back-pressure, then each word is checked in order.
  initial begin
    fifo_result_t want;
    int stall;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        m_tready = 1'b0;
      end
      @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: m_tdata=%h", m_tdata);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("data_out", brf_pkg::COUNT_W'(want.rbyte),
                    brf_pkg::COUNT_W'(m_tdata[7:0]));
        check_field("ok", brf_pkg::COUNT_W'(want.ok), brf_pkg::COUNT_W'(m_tdata[8]));
        check_field("match_offset", brf_pkg::COUNT_W'(want.hit_offset),
                    brf_pkg::COUNT_W'(m_tdata[16:9]));
        check_field("level", brf_pkg::COUNT_W'(want.fill),
                    brf_pkg::COUNT_W'(m_tdata[24:17]));
        check_field("burst_count", want.burst, m_tdata[40:25]);
      end
    end
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty ring first, then a short burst, peeks with clamping, searches,
    // unknown codes, reads, a peek, a flush, a read on the emptied ring, a refill.
    dir_steps.push_back({rq(brf_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 1'b0), 1'b1,
                         rs(8'h00, 1'b0, 8'd0, 8'd0, 16'd0)});
    dir_steps.push_back({rq(brf_pkg::REQ_PEEK, 8'h00, 8'hFF, 8'h00, 1'b1), 1'b1,
                         rs(8'h00, 1'b0, 8'd0, 8'd0, 16'd0)});
    dir_steps.push_back({rq(brf_pkg::REQ_FIND, 8'h00, 8'h00, 8'h00, 1'b0), 1'b1,
                         rs(8'h00, 1'b0, 8'd0, 8'd0, 16'd0)});
    dir_steps.push_back({rq(brf_pkg::REQ_WRITE, 8'h00, 8'h00, 8'h00, 1'b0), 1'b1,
                         rs(8'h00, 1'b1, 8'd0, 8'd1, 16'd1)});
    dir_steps.push_back({rq(brf_pkg::REQ_WRITE, 8'hFF, 8'h00, 8'h00, 1'b0), 1'b1,
                         rs(8'h00, 1'b1, 8'd0, 8'd2, 16'd2)});
    dir_steps.push_back({rq(brf_pkg::REQ_WRITE, 8'hA5, 8'h00, 8'h00, 1'b1), 1'b1,
                         rs(8'h00, 1'b1, 8'd0, 8'd3, 16'd3)});
    dir_steps.push_back({rq(brf_pkg::REQ_WRITE, 8'h5A, 8'h00, 8'h00, 1'b0), 1'b1,
                         rs(8'h00, 1'b1, 8'd0, 8'd4, 16'd1)});
    dir_steps.push_back({rq(brf_pkg::REQ_PEEK, 8'h00, 8'h00, 8'h00, 1'b0), 1'b1,
                         rs(8'h00, 1'b1, 8'd0, 8'd4, 16'd1)});
    dir_steps.push_back({rq(brf_pkg::REQ_PEEK, 8'h00, 8'hFF, 8'h00, 1'b0), 1'b1,
                         rs(8'h5A, 1'b1, 8'd0, 8'd4, 16'd1)});
    dir_steps.push_back({rq(brf_pkg::REQ_PEEK, 8'h00, 8'h02, 8'h00, 1'b0), 1'b0,
                         rs(8'h00, 1'b0, 8'd0, 8'd0, 16'd0)});
    dir_steps.push_back({rq(brf_pkg::REQ_FIND, 8'h00, 8'h00, 8'hFF, 1'b0), 1'b1,
                         rs(8'h00, 1'b1, 8'd1, 8'd4, 16'd1)});
    dir_steps.push_back({rq(brf_pkg::REQ_FIND, 8'h00, 8'h00, 8'h5A, 1'b1), 1'b0,
                         rs(8'h00, 1'b0, 8'd0, 8'd0, 16'd0)});
    dir_steps.push_back({rq(brf_pkg::REQ_FIND, 8'h00, 8'h00, 8'h11, 1'b0), 1'b1,
                         rs(8'h00, 1'b0, 8'd0, 8'd4, 16'd1)});
    dir_steps.push_back({rq(REQ_RSVD5, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b1,
                         rs(8'h00, 1'b0, 8'd0, 8'd4, 16'd1)});
    dir_steps.push_back({rq(REQ_RSVD6, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0,
                         rs(8'h00, 1'b0, 8'd0, 8'd0, 16'd0)});
    dir_steps.push_back({rq(REQ_RSVD7, 8'h12, 8'h34, 8'h56, 1'b1), 1'b1,
                         rs(8'h00, 1'b0, 8'd0, 8'd4, 16'd1)});
    dir_steps.push_back({rq(brf_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 1'b0), 1'b1,
                         rs(8'h00, 1'b1, 8'd0, 8'd3, 16'd2)});
    dir_steps.push_back({rq(brf_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 1'b1), 1'b1,
                         rs(8'hFF, 1'b1, 8'd0, 8'd2, 16'd3)});
    dir_steps.push_back({rq(brf_pkg::REQ_PEEK, 8'h00, 8'h00, 8'h00, 1'b1), 1'b1,
                         rs(8'hA5, 1'b1, 8'd0, 8'd2, 16'd0)});
    dir_steps.push_back({rq(brf_pkg::REQ_FLUSH, 8'h00, 8'h00, 8'h00, 1'b1), 1'b1,
                         rs(8'h00, 1'b1, 8'd0, 8'd0, 16'd0)});
    dir_steps.push_back({rq(brf_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 1'b1), 1'b1,
                         rs(8'h00, 1'b0, 8'd0, 8'd0, 16'd0)});
    dir_steps.push_back({rq(brf_pkg::REQ_WRITE, 8'h80, 8'h00, 8'h00, 1'b0), 1'b0,
                         rs(8'h00, 1'b0, 8'd0, 8'd0, 16'd0)});
    dir_steps.push_back({rq(brf_pkg::REQ_WRITE, 8'h01, 8'h00, 8'h00, 1'b0), 1'b0,
                         rs(8'h00, 1'b0, 8'd0, 8'd0, 16'd0)});
    dir_steps.push_back({rq(brf_pkg::REQ_FIND, 8'h00, 8'h00, 8'h01, 1'b0), 1'b1,
                         rs(8'h00, 1'b1, 8'd1, 8'd2, 16'd2)});
    dir_steps.push_back({rq(brf_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 1'b1), 1'b1,
                         rs(8'h80, 1'b1, 8'd0, 8'd1, 16'd3)});

    write_mode(MODE_DROP);
    foreach (dir_steps[i]) send_request(dir_steps[i].req, dir_steps[i].chk, dir_steps[i].want);

    // Fill past full with push-out, hold at full in drop mode, drain to
    // empty, fill again to the drop limit, then a mixed run with flushes.
    run_phase(MODE_PUSHOUT, 400, 85, 3, 5, 5, 0);
    run_phase(MODE_DROP, 400, 60, 20, 8, 8, 0);
    run_phase(MODE_PUSHOUT, 400, 10, 75, 5, 5, 1);
    run_phase(MODE_DROP, 400, 80, 5, 5, 6, 0);
    run_phase(MODE_PUSHOUT, 350, 40, 35, 8, 8, 5);

    wait_drained();
    repeat (16) @(posedge clk);
    if (!failed && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
